[design/q2e_pkg.sv]
// Shared types, widths and constants of the quaternion to Euler angle pipeline.
// Holds the arctangent table and the final rounding and saturation function.
// Depends on nothing; every design file refers to it by scoped names.
package q2e_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_STAGES = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;

  localparam int QW = 16;
  localparam int PW = 32;
  localparam int SW = 36;
  localparam int RW = 58;
  localparam int RTW = 29;
  localparam int VW = 45;
  localparam int ZW = 28;
  localparam int SHW = 6;
  localparam int NORM_BITS = 40;
  localparam int OW = 17;

  localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(64'sd26353589);
  localparam logic signed [OW-1:0] PI_Q13 = OW'(25736);
  localparam logic signed [OW-1:0] HALF_PI_Q13 = OW'(12868);

  typedef struct packed {
    logic signed [SW-1:0] ry;
    logic signed [SW-1:0] rx;
    logic signed [SW-1:0] yy;
    logic signed [SW-1:0] yx;
    logic signed [SW-1:0] a;
    logic                 clamp;
    logic [RW-1:0]        rem;
    logic [RTW-1:0]       root;
  } item_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic                 clamp;
    logic                 neg;
  } atan_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(13176795);
      1: r = ZW'(7778716);
      2: r = ZW'(4110060);
      3: r = ZW'(2086331);
      4: r = ZW'(1047214);
      5: r = ZW'(524117);
      6: r = ZW'(262123);
      7: r = ZW'(131069);
      8: r = ZW'(65536);
      9: r = ZW'(32768);
      10: r = ZW'(16384);
      11: r = ZW'(8192);
      12: r = ZW'(4096);
      13: r = ZW'(2048);
      14: r = ZW'(1024);
      15: r = ZW'(512);
      16: r = ZW'(256);
      17: r = ZW'(128);
      18: r = ZW'(64);
      19: r = ZW'(32);
      20: r = ZW'(16);
      21: r = ZW'(8);
      22: r = ZW'(4);
      23: r = ZW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OW-1:0] q13_sat(input logic signed [ZW-1:0] z,
                                                   input logic signed [OW-1:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] l;
    t = z + ZW'(1024);
    r = t >>> 11;
    l = ZW'(lim);
    if (r > l) begin
      r = l;
    end else if (r < -l) begin
      r = -l;
    end
    return r[OW-1:0];
  endfunction

endpackage

[design/q2e_prep.sv]
// Front end: quaternion products, the three angle operands and the asin square.
// Four register stages; depends on q2e_pkg.
module q2e_prep (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [q2e_pkg::QW-1:0] qw,
  input  logic signed [q2e_pkg::QW-1:0] qx,
  input  logic signed [q2e_pkg::QW-1:0] qy,
  input  logic signed [q2e_pkg::QW-1:0] qz,
  output logic                         out_valid,
  output q2e_pkg::item_t               out_item
);

  logic [3:0] vld;
  logic signed [q2e_pkg::PW-1:0] p_wx, p_yz, p_xx, p_yy, p_zz, p_wy, p_zx, p_wz, p_xy;
  q2e_pkg::item_t st2, st3;
  q2e_pkg::item_t st3_next, out_next;
  logic signed [q2e_pkg::RW-1:0] asq;
  logic signed [q2e_pkg::RTW-1:0] a29;
  logic signed [q2e_pkg::RW-1:0] ae;
  logic clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2.ry <= (q2e_pkg::SW'(p_wx) + q2e_pkg::SW'(p_yz)) <<< 1;
      st2.rx <= q2e_pkg::ONE_Q28 - ((q2e_pkg::SW'(p_xx) + q2e_pkg::SW'(p_yy)) <<< 1);
      st2.a <= (q2e_pkg::SW'(p_wy) - q2e_pkg::SW'(p_zx)) <<< 1;
      st2.yy <= (q2e_pkg::SW'(p_wz) + q2e_pkg::SW'(p_xy)) <<< 1;
      st2.yx <= q2e_pkg::ONE_Q28 - ((q2e_pkg::SW'(p_yy) + q2e_pkg::SW'(p_zz)) <<< 1);
      st2.clamp <= 1'b0;
      st2.rem <= '0;
      st2.root <= '0;
    end
  end

  always_comb begin
    clamp = (st2.a > q2e_pkg::ONE_Q28) || (st2.a < -q2e_pkg::ONE_Q28);
    a29 = clamp ? '0 : st2.a[q2e_pkg::RTW-1:0];
    ae = q2e_pkg::RW'(a29);
    st3_next = st2;
    st3_next.clamp = clamp;
    out_next = st3;
    out_next.rem = (q2e_pkg::RW'(1) << 56) - q2e_pkg::RW'(asq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3 <= st3_next;
      asq <= ae * ae;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_next;
    end
  end

  assign out_valid = vld[3];

endmodule

[design/q2e_isqrt.sv]
// Pipelined floor square root of the asin remainder, one root bit per stage.
// The other operands of the item travel alongside; depends on q2e_pkg.
module q2e_isqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  q2e_pkg::item_t in_item,
  output logic           out_valid,
  output q2e_pkg::item_t out_item
);

  localparam int N = q2e_pkg::RTW;

  q2e_pkg::item_t stg [0:N];
  logic [N:0] vld;

  assign stg[0] = in_item;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam int B = N - 1 - k;
    logic [q2e_pkg::RW-1:0] d;
    q2e_pkg::item_t nxt;

    always_comb begin
      d = (q2e_pkg::RW'(stg[k].root) << (B + 1)) + (q2e_pkg::RW'(1) << (2 * B));
      nxt = stg[k];
      if (stg[k].rem >= d) begin
        nxt.rem = stg[k].rem - d;
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_item = stg[N];
  assign out_valid = vld[N];

endmodule

[design/q2e_norm.sv]
// Operand scaling for the arctangent: finds the leading one, shifts both operands
// up to the working range and folds the left half plane. Depends on q2e_pkg.
module q2e_norm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [q2e_pkg::SW-1:0] y,
  input  logic signed [q2e_pkg::SW-1:0] x,
  input  logic                          clamp,
  input  logic                          neg,
  output logic                          out_valid,
  output q2e_pkg::atan_t                out_v
);

  logic [2:0] vld;
  logic signed [q2e_pkg::SW-1:0] x1, y1, x2, y2;
  logic [q2e_pkg::SW-1:0] ax, ay, m1;
  logic zero1, zero2, cl1, cl2, ng1, ng2;
  logic [q2e_pkg::SHW-1:0] sh, sh2;
  logic signed [q2e_pkg::VW-1:0] xs, ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_comb begin
    ax = x[q2e_pkg::SW-1] ? q2e_pkg::SW'(-x) : q2e_pkg::SW'(x);
    ay = y[q2e_pkg::SW-1] ? q2e_pkg::SW'(-y) : q2e_pkg::SW'(y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      y1 <= y;
      m1 <= ax | ay;
      zero1 <= (x == '0) && (y == '0);
      cl1 <= clamp;
      ng1 <= neg;
    end
  end

  always_comb begin
    sh = '0;
    for (int i = 0; i < q2e_pkg::SW; i++) begin
      if (m1[i]) begin
        sh = (i < q2e_pkg::NORM_BITS) ? q2e_pkg::SHW'(q2e_pkg::NORM_BITS - i) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= x1;
      y2 <= y1;
      sh2 <= sh;
      zero2 <= zero1;
      cl2 <= cl1;
      ng2 <= ng1;
    end
  end

  always_comb begin
    xs = q2e_pkg::VW'(x2) <<< sh2;
    ys = q2e_pkg::VW'(y2) <<< sh2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_v.zero <= zero2;
      out_v.clamp <= cl2;
      out_v.neg <= ng2;
      if (xs < 0) begin
        if (ys >= 0) begin
          out_v.x <= ys;
          out_v.y <= -xs;
          out_v.z <= q2e_pkg::HALF_PI_Q24;
        end else begin
          out_v.x <= -ys;
          out_v.y <= xs;
          out_v.z <= -q2e_pkg::HALF_PI_Q24;
        end
      end else begin
        out_v.x <= xs;
        out_v.y <= ys;
        out_v.z <= '0;
      end
    end
  end

  assign out_valid = vld[2];

endmodule

[design/q2e_cordic.sv]
// Unrolled vectoring CORDIC, one micro-rotation per register stage.
// Accumulates the angle in Q.24 from the table in q2e_pkg.
module q2e_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  q2e_pkg::atan_t in_v,
  output logic           out_valid,
  output q2e_pkg::atan_t out_v
);

  localparam int N = q2e_pkg::CORDIC_STAGES;

  q2e_pkg::atan_t stg [0:N];
  logic [N:0] vld;

  assign stg[0] = in_v;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_rot
    q2e_pkg::atan_t nxt;
    logic signed [q2e_pkg::VW-1:0] dx, dy;

    always_comb begin
      dx = stg[i].y >>> i;
      dy = stg[i].x >>> i;
      nxt = stg[i];
      if (stg[i].y > 0) begin
        nxt.x = stg[i].x + dx;
        nxt.y = stg[i].y - dy;
        nxt.z = stg[i].z + q2e_pkg::atan_tab(i);
      end else begin
        nxt.x = stg[i].x - dx;
        nxt.y = stg[i].y + dy;
        nxt.z = stg[i].z - q2e_pkg::atan_tab(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[i+1] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_v = stg[N];
  assign out_valid = vld[N];

endmodule

[design/quaternion_to_euler_angles.sv]
// Top level of the quaternion to Euler angle converter (Z-Y-X order).
// Instantiates q2e_prep, q2e_isqrt, q2e_norm and q2e_cordic; uses q2e_pkg.
//
// Usage: a quaternion item enters on the s_axis group and one result item leaves
// on the m_axis group for every item taken in. Roll and yaw are arctangents of
// the rotated axes, pitch is an arcsine computed as an arctangent against a
// pipelined square root; pitch is clamped to plus or minus half pi and flagged
// when its sine exceeds one in magnitude. Roll and yaw are Q2.13 radians, pitch Q1.13.
// From acceptance to the result showing on m_axis an item passes through the
// register stages of products and sums, 29 square root stages, three scaling stages,
// 16 rotation stages and the output register. One item is taken every cycle
// unless the receiver stalls; the square root and rotation set the depth, not the rate.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled receiver holds every item in place and
// s_axis_tready falls; nothing is lost or repeated. Reset clears all valid bits,
// including that of the output register, and the block is ready in the first
// cycle after it.
module quaternion_to_euler_angles (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // qw, qx, qy, qz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // roll_angle, pitch_angle, yaw_angle, pitch_clamped
);

  logic en;
  logic p_valid, s_valid, n_valid, c_valid;
  logic n_valid_p, n_valid_y, c_valid_p, c_valid_y;
  q2e_pkg::item_t p_item, s_item;
  q2e_pkg::atan_t n_roll, n_pitch, n_yaw, c_roll, c_pitch, c_yaw;
  logic signed [q2e_pkg::OW-1:0] roll_r, pitch_r, yaw_r;
  logic signed [q2e_pkg::SW-1:0] root_ext;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  q2e_prep u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_axis_tvalid),
    .qw(s_axis_tdata[15:0]), .qx(s_axis_tdata[31:16]),
    .qy(s_axis_tdata[47:32]), .qz(s_axis_tdata[63:48]),
    .out_valid(p_valid), .out_item(p_item)
  );

  q2e_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid), .in_item(p_item),
    .out_valid(s_valid), .out_item(s_item)
  );

  assign root_ext = $signed({{(q2e_pkg::SW - q2e_pkg::RTW){1'b0}}, s_item.root});

  q2e_norm u_norm_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .y(s_item.ry), .x(s_item.rx),
    .clamp(1'b0), .neg(1'b0), .out_valid(n_valid), .out_v(n_roll)
  );

  q2e_norm u_norm_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .y(s_item.a), .x(root_ext),
    .clamp(s_item.clamp), .neg(s_item.a[q2e_pkg::SW-1]),
    .out_valid(n_valid_p), .out_v(n_pitch)
  );

  q2e_norm u_norm_yaw (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .y(s_item.yy), .x(s_item.yx),
    .clamp(1'b0), .neg(1'b0), .out_valid(n_valid_y), .out_v(n_yaw)
  );

  q2e_cordic u_cordic_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(n_valid), .in_v(n_roll),
    .out_valid(c_valid), .out_v(c_roll)
  );

  q2e_cordic u_cordic_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(n_valid_p), .in_v(n_pitch),
    .out_valid(c_valid_p), .out_v(c_pitch)
  );

  q2e_cordic u_cordic_yaw (
    .clk(clk), .rst(rst), .en(en), .in_valid(n_valid_y), .in_v(n_yaw),
    .out_valid(c_valid_y), .out_v(c_yaw)
  );

  always_comb begin
    roll_r = c_roll.zero ? '0 : q2e_pkg::q13_sat(c_roll.z, q2e_pkg::PI_Q13);
    yaw_r = c_yaw.zero ? '0 : q2e_pkg::q13_sat(c_yaw.z, q2e_pkg::PI_Q13);
    if (c_pitch.clamp) begin
      pitch_r = c_pitch.neg ? -q2e_pkg::HALF_PI_Q13 : q2e_pkg::HALF_PI_Q13;
    end else if (c_pitch.zero) begin
      pitch_r = '0;
    end else begin
      pitch_r = q2e_pkg::q13_sat(c_pitch.z, q2e_pkg::HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {c_pitch.clamp, yaw_r[15:0], pitch_r[14:0], roll_r[15:0]};
    end
  end

  // The three channels of the pipeline must stay in step.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (c_valid == c_valid_p) && (c_valid == c_valid_y) && (n_valid == n_valid_p))
    else $error("angle channels out of step");

  a_clamp_pitch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[47] |->
      ($signed(m_axis_tdata[30:16]) == 15'sd12868 ||
       $signed(m_axis_tdata[30:16]) == -15'sd12868))
    else $error("clamped pitch is not half pi");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd25736 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd25736))
    else $error("roll out of range");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");

endmodule

[dv/tb_quaternion_to_euler_angles.sv]
// Self-checking testbench for quaternion_to_euler_angles: drives quaternion items,
// predicts roll, pitch and yaw in fixed point and checks every result item in order.
// Depends on the RTL top level only; stalls and gaps are random on both streams.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;

  typedef struct packed {
    logic        clamped;
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
  } angles_t;

  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint NORM_LIMIT = 64'sd1 << 40;
  localparam longint HALF_PI_Q24 = 64'sd26353589;
  localparam longint PI_Q13 = 25736;
  localparam longint HALF_PI_Q13 = 12868;
  localparam int ROT_STEPS = 16;
  localparam int LIMIT_CYCLES = 400000;

  localparam longint ATAN_STEP [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  angles_t expected_angles[$];
  int      errors = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      clamps_seen = 0;
  int      cycles = 0;
  int      stall_mode = 0;

  quaternion_to_euler_angles u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while ((x < 0 ? -x : x) < NORM_LIMIT && (y < 0 ? -y : y) < NORM_LIMIT) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q24;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q24;
      end
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic longint to_q13(longint z, longint lim);
    longint r;
    r = (z + 1024) >>> 11;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_from_quat(logic [63:0] q);
    longint w;
    longint x;
    longint y;
    longint z;
    longint a;
    longint s;
    longint p;
    angles_t r;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    r.roll = 16'(to_q13(vector_angle(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y)),
                        PI_Q13));
    a = 2 * (w * y - z * x);
    r.clamped = 1'b0;
    if (a > ONE_Q28) begin
      p = HALF_PI_Q13;
      r.clamped = 1'b1;
    end else if (a < -ONE_Q28) begin
      p = -HALF_PI_Q13;
      r.clamped = 1'b1;
    end else begin
      s = root_floor(longint'(ONE_Q28 * ONE_Q28 - a * a));
      p = to_q13(vector_angle(a, s), HALF_PI_Q13);
    end
    r.pitch = 15'(p);
    r.yaw = 16'(to_q13(vector_angle(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z)),
                       PI_Q13));
    return r;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_angles.size());
      $display("quaternion_to_euler_angles: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 29) == 0) ? 1'b1 : m_axis_tready & 1'b0;
      endcase
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    angles_t got;
    angles_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result item, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_angles.pop_front();
        results_seen++;
        if (got.clamped) clamps_seen++;
        if (got.roll !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, $signed(want.roll),
                   $signed(got.roll));
          errors++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, $signed(want.pitch),
                   $signed(got.pitch));
          errors++;
        end
        if (got.yaw !== want.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, $signed(want.yaw),
                   $signed(got.yaw));
          errors++;
        end
        if (got.clamped !== want.clamped) begin
          $display("%0t: pitch_clamped expected %0b actual %0b", $time, want.clamped,
                   got.clamped);
          errors++;
        end
      end
    end
  end

  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x, w};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_angles.push_back(euler_from_quat({z, y, x, w}));
    items_sent++;
    gap = short_or_long_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic test_directed();
    send_quat(16'sd16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(0, 16'sd8192, 16'sd8192, 0);
    send_quat(16'sd16384, 0, 16'sd8192, 0);
    send_quat(16'sd16384, 0, -16'sd8192, 0);
    send_quat(16'sd16384, 0, 16'sd16384, 0);
    send_quat(16'sd16384, 0, -16'sd16384, 0);
    send_quat(0, 16'sd16384, 0, 0);
    send_quat(0, 0, 16'sd16384, 0);
    send_quat(0, 0, 0, 16'sd16384);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(16'sd11585, 16'sd11585, 0, 0);
    send_quat(16'sd11585, 0, 0, -16'sd11585);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_unit_quats(input int n);
    real c [4];
    real mag;
    real stretch;
    logic [15:0] v [4];
    for (int k = 0; k < n; k++) begin
      mag = 0.0;
      for (int j = 0; j < 4; j++) begin
        c[j] = real'($signed($urandom_range(0, 65535) - 32768));
        mag = mag + c[j] * c[j];
      end
      if (mag == 0.0) mag = 1.0;
      stretch = ($urandom_range(0, 4) == 0) ? 1.0 + real'($urandom_range(0, 300)) / 10000.0
                                             : 1.0;
      for (int j = 0; j < 4; j++) begin
        v[j] = 16'($rtoi(c[j] * 16384.0 * stretch / $sqrt(mag)));
      end
      send_quat(v[0], v[1], v[2], v[3]);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_raw_quats(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_quat(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else begin
        send_quat(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384));
      end
    end
  endtask

  task automatic test_back_to_back(input int n);
    for (int k = 0; k < n; k++) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {$urandom(), $urandom()};
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      expected_angles.push_back(euler_from_quat(s_axis_tdata));
      items_sent++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_unit_quats(250);
    wait_drained();
    test_raw_quats(100);
    test_back_to_back(50);
    wait_drained();
    $display("Sent %0d quaternion items and checked %0d results, %0d of them with pitch clamped.",
             items_sent, results_seen, clamps_seen);
    $display("Directed extremes, unit and stretched quaternions and raw 16-bit values were used.");
    if (errors == 0) begin
      $display("quaternion_to_euler_angles: match");
    end else begin
      $display("quaternion_to_euler_angles: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
design/q2e_pkg.sv
design/q2e_prep.sv
design/q2e_isqrt.sv
design/q2e_norm.sv
design/q2e_cordic.sv
design/quaternion_to_euler_angles.sv
dv/tb_quaternion_to_euler_angles.sv
